// ===== hdl/queue_with_middle_insert_top_assert.svh =====
// ---------------------------------------------------------------------------
// queue_with_middle_insert_top_assert.svh
// Assertion macros for the middle-insert queue, clocked on i_clk and
// disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUEUE_WITH_MIDDLE_INSERT_TOP_ASSERT_SVH
`define QUEUE_WITH_MIDDLE_INSERT_TOP_ASSERT_SVH

// condition holds at every edge
`define QMI_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds after the antecedent, checked with non-overlapping implication
`define QMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequence holds at the same edge as the antecedent
`define QMI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qmi_pkg.sv =====
// ---------------------------------------------------------------------------
// qmi_pkg
// Types and constants shared by the middle-insert queue modules.
// ---------------------------------------------------------------------------
package qmi_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int ID_WIDTH    = 16;
    localparam int FRONT_CAP   = (QUEUE_DEPTH + 1) / 2;
    localparam int BACK_CAP    = QUEUE_DEPTH / 2;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int HALF_W      = $clog2(FRONT_CAP + 1);
    localparam int OCC_W       = 11;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_JOIN_TAIL = 2'd0,
        REQ_JOIN_MID  = 2'd1,
        REQ_SERVE     = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } t_cell_op;

    // broadcast to every cell of the row
    typedef struct packed {
        t_cell_op            op;
        logic [IDX_W-1:0]    pos;
        logic [ID_WIDTH-1:0] id;
    } t_cell_cmd;

    typedef struct packed {
        logic [HALF_W-1:0] front_count;
        logic [HALF_W-1:0] back_count;
    } t_qmi_stat;

endpackage

// ===== hdl/qmi_cell.sv =====
// ---------------------------------------------------------------------------
// qmi_cell
// One slot of the queue row: holds one identifier and takes its left or
// right neighbor's value on an insert or a serve.
// ---------------------------------------------------------------------------
module qmi_cell (
    input  logic                         i_clk,
    input  logic [qmi_pkg::IDX_W-1:0]    i_index,
    input  qmi_pkg::t_cell_cmd           i_cmd,
    input  logic [qmi_pkg::ID_WIDTH-1:0] i_left,
    input  logic [qmi_pkg::ID_WIDTH-1:0] i_right,
    output logic [qmi_pkg::ID_WIDTH-1:0] o_data
);
    import qmi_pkg::*;

    logic [ID_WIDTH-1:0] r_data;
    logic [ID_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            OP_SHIFT: begin
                n_data = i_right;
            end
            OP_INSERT: begin
                // slots behind the insert point move one place back
                if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.id;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/qmi_ctrl.sv =====
// ---------------------------------------------------------------------------
// qmi_ctrl
// Half counters, request decode, rebalancing and the result register.
// ---------------------------------------------------------------------------
module qmi_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [qmi_pkg::REQ_W-1:0]    i_req,
    input  logic [qmi_pkg::ID_WIDTH-1:0] i_id,
    input  logic [qmi_pkg::ID_WIDTH-1:0] i_head,
    output qmi_pkg::t_cell_cmd           o_cmd,
    output qmi_pkg::t_qmi_stat           o_stat,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [qmi_pkg::ID_WIDTH-1:0] o_served,
    output logic [qmi_pkg::STAT_W-1:0]   o_status,
    output logic [qmi_pkg::OCC_W-1:0]    o_occ
);
    import qmi_pkg::*;

    logic [HALF_W-1:0]   r_front;
    logic [HALF_W-1:0]   r_back;
    logic [HALF_W-1:0]   n_front;
    logic [HALF_W-1:0]   n_back;
    logic                r_m_valid;
    logic [ID_WIDTH-1:0] r_served;
    t_status             r_status;
    logic [OCC_W-1:0]    r_occ;

    logic                accept;
    logic [OCC_W-1:0]    total;
    logic [OCC_W-1:0]    n_total;
    logic                full;
    logic [ID_WIDTH-1:0] served;
    t_status             status;
    t_cell_cmd           cmd;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign total      = OCC_W'(r_front) + OCC_W'(r_back);
    assign full       = (total >= OCC_W'(QUEUE_DEPTH)) || (r_back >= HALF_W'(BACK_CAP));

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        served  = '0;
        status  = ST_DONE;
        cmd.op  = OP_HOLD;
        cmd.pos = '0;
        cmd.id  = i_id;
        if (accept) begin
            unique case (t_req'(i_req))
                REQ_JOIN_TAIL: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op  = OP_INSERT;
                        cmd.pos = total[IDX_W-1:0];
                        n_back  = r_back + 1'b1;
                    end
                end
                REQ_JOIN_MID: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        // the middle is the boundary between the two halves
                        cmd.op  = OP_INSERT;
                        cmd.pos = IDX_W'(r_front);
                        n_back  = r_back + 1'b1;
                    end
                end
                REQ_SERVE: begin
                    if (r_front == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        cmd.op  = OP_SHIFT;
                        served  = i_head;
                        n_front = r_front - 1'b1;
                    end
                end
                default: begin
                    status = ST_DONE;
                end
            endcase
        end
        // back half larger: its first entry becomes the front tail
        if (n_back > n_front && n_back != '0 && n_front < HALF_W'(FRONT_CAP)) begin
            n_front = n_front + 1'b1;
            n_back  = n_back - 1'b1;
        end
    end

    assign n_total = OCC_W'(n_front) + OCC_W'(n_back);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_back    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_served <= served;
            r_status <= status;
            r_occ    <= n_total;
        end
    end

    assign o_cmd              = cmd;
    assign o_stat.front_count = r_front;
    assign o_stat.back_count  = r_back;
    assign o_m_tvalid         = r_m_valid;
    assign o_served           = r_served;
    assign o_status           = r_status;
    assign o_occ              = r_occ;

endmodule

// ===== hdl/queue_with_middle_insert_top.sv =====
// output: a result beat is registered when its request beat is accepted and appears in the next cycle
// throughput: one request per cycle while the result side keeps taking beats;
//   every successful join or serve updates the whole cell row in a single shift or insert step
// reset: synchronous, active low; clears the half counters and the result
//   valid, the cell contents are left as they are and are never read unwritten
// ---------------------------------------------------------------------------
// queue_with_middle_insert_top
// Queue with tail joins, middle joins and head serves, kept as a row of
// cells with a front/back half split tracked by the controller.
// ---------------------------------------------------------------------------
`include "queue_with_middle_insert_top_assert.svh"

module queue_with_middle_insert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] member_id
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] served_id, [26:16] occupancy, rest zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);
    import qmi_pkg::*;

    t_cell_cmd           w_cmd;
    t_qmi_stat           w_stat;
    logic [ID_WIDTH-1:0] w_data [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] w_served;
    logic [OCC_W-1:0]    w_occ;

    qmi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_req      (i_s_tuser),
        .i_id       (i_s_tdata[ID_WIDTH-1:0]),
        .i_head     (w_data[0]),
        .o_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_served   (w_served),
        .o_status   (o_m_tuser),
        .o_occ      (w_occ)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [ID_WIDTH-1:0] w_left;
        logic [ID_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        qmi_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    assign o_m_tdata = {5'd0, w_occ, w_served};

    // front half equals the back half or is one longer
    `QMI_ASSERT_ALWAYS(a_balance, (w_stat.front_count == w_stat.back_count) || (w_stat.front_count == w_stat.back_count + 1'b1), "halves out of balance")
    // an empty serve reports no identifier and an empty queue
    `QMI_ASSERT_SAME(a_empty_result, o_m_tvalid && o_m_tuser == ST_EMPTY, w_occ == '0 && w_served == '0, "bad empty serve result")
    // a serve with a non-empty front half succeeds
    `QMI_ASSERT_NEXT(a_serve_ok, i_s_tvalid && o_s_tready && i_s_tuser == REQ_SERVE && w_stat.front_count != '0, o_m_tvalid && o_m_tuser == ST_DONE, "serve of non-empty queue failed")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the middle-insert queue against a two-half queue model kept in the
// bench: tail joins, middle joins, head serves, full drops, empty serves and
// the unused selector, under varied stream idling and a long result stall.
// ---------------------------------------------------------------------------
module testbench;
    import qmi_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         FILL_HOLD      = 400;
    localparam int         DRAIN_COUNT    = 400;
    localparam int         PHASE_ITEMS    = 85;

    typedef struct {
        logic [15:0] served_id;
        t_status     status;
        logic [10:0] occupancy;
    } t_queue_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;   // [15:0] member_id
    logic [1:0]  i_s_tuser = '0;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;        // [15:0] served_id, [26:16] occupancy, rest zero
    logic [1:0]  o_m_tuser;        // [1:0] status

    // bench copy of the two halves
    logic [15:0]   front_half[$];
    logic [15:0]   back_half[$];
    t_queue_result pending_results[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_request = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;

    queue_with_middle_insert_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // back half may never outgrow the front half
    function automatic void rebalance_halves();
        logic [15:0] moved;
        if (back_half.size() > front_half.size() && back_half.size() != 0 &&
            front_half.size() < FRONT_CAP) begin
            moved = back_half[0];
            back_half.delete(0);
            front_half.insert(front_half.size(), moved);
        end
    endfunction

    function automatic t_queue_result predict_request(logic [1:0] req, logic [15:0] id);
        t_queue_result r;
        r.served_id = '0;
        r.status    = ST_DONE;
        if (req == REQ_JOIN_TAIL || req == REQ_JOIN_MID) begin
            if (front_half.size() + back_half.size() >= QUEUE_DEPTH ||
                back_half.size() >= BACK_CAP) begin
                r.status = ST_FULL;
            end else begin
                if (req == REQ_JOIN_TAIL) begin
                    back_half.insert(back_half.size(), id);
                end else begin
                    back_half.insert(0, id);
                end
                rebalance_halves();
            end
        end else if (req == REQ_SERVE) begin
            if (front_half.size() == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.served_id = front_half[0];
                front_half.delete(0);
                rebalance_halves();
            end
        end
        r.occupancy = 11'(front_half.size() + back_half.size());
        return r;
    endfunction

    // valid stays high from one beat to the next unless an idle cycle is rolled
    task automatic send_request(logic [1:0] req, logic [15:0] id);
        t_queue_result res;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= id;
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        res = predict_request(req, id);
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    function automatic logic [1:0] random_join();
        return $urandom_range(1) ? REQ_JOIN_MID : REQ_JOIN_TAIL;
    endfunction

    always @(negedge i_clk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_queue_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no request waiting: tdata %h tuser %h",
                       o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_m_tdata[15:0] !== want.served_id) begin
                    $error("served_id expected %h actual %h", want.served_id, o_m_tdata[15:0]);
                    error_count++;
                end
                if (o_m_tdata[26:16] !== want.occupancy) begin
                    $error("occupancy expected %0d actual %0d", want.occupancy,
                           o_m_tdata[26:16]);
                    error_count++;
                end
                if (o_m_tdata[31:27] !== 5'd0) begin
                    $error("tdata padding expected 0 actual %h", o_m_tdata[31:27]);
                    error_count++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_directed();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(REQ_SERVE, 16'h0000);       // serve on empty
        send_request(REQ_UNUSED, 16'hFFFF);      // unused selector on empty
        send_request(REQ_JOIN_TAIL, 16'h0000);
        send_request(REQ_JOIN_TAIL, 16'hFFFF);
        send_request(REQ_JOIN_MID, 16'h8000);    // even length, lands in the middle
        send_request(REQ_JOIN_MID, 16'h0001);    // odd length, just behind the centre
        send_request(REQ_JOIN_TAIL, 16'h5A5A);
        send_request(REQ_UNUSED, 16'h1234);
        repeat (5) send_request(REQ_SERVE, 16'hFFFF);
        send_request(REQ_SERVE, 16'h0000);
        send_request(REQ_JOIN_MID, 16'hA5A5);    // middle join on empty
        send_request(REQ_SERVE, 16'h0000);
        send_request(REQ_JOIN_MID, 16'h7FFF);
        send_request(REQ_JOIN_MID, 16'h0F0F);
        send_request(REQ_JOIN_TAIL, 16'hF0F0);
        repeat (4) send_request(REQ_SERVE, 16'h0000);
    endtask

    // fill to the brim, starting behind a stalled result side, drop joins, then drain part way
    task automatic test_full_queue();
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rx_hold_request = FILL_HOLD;
        repeat (QUEUE_DEPTH) send_request(random_join(), 16'($urandom));
        send_request(REQ_JOIN_TAIL, 16'($urandom));
        send_request(REQ_JOIN_MID, 16'($urandom));
        send_request(REQ_UNUSED, 16'($urandom));
        send_request(REQ_SERVE, 16'($urandom));
        send_request(REQ_JOIN_MID, 16'($urandom));
        send_request(REQ_JOIN_TAIL, 16'($urandom));
        tx_idle_pct  = 36;
        rx_stall_pct = 36;
        repeat (DRAIN_COUNT) send_request(REQ_SERVE, 16'($urandom));
    endtask

    task automatic test_random_phase(int tx_pct, int rx_pct, int n_items);
        int sent;
        int kind;
        int burst;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            kind  = $urandom_range(9);
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (kind < 4) begin
                    send_request(random_join(), 16'($urandom));
                end else if (kind < 8) begin
                    if ($urandom_range(9) == 0) begin
                        send_request(random_join(), 16'($urandom));
                    end else begin
                        send_request(REQ_SERVE, 16'($urandom));
                    end
                end else begin
                    send_request(2'($urandom_range(3)), 16'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_queue();
        test_random_phase(0, 0, PHASE_ITEMS);
        test_random_phase(86, 0, PHASE_ITEMS);
        test_random_phase(0, 86, PHASE_ITEMS);
        test_random_phase(36, 36, PHASE_ITEMS);
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/qmi_pkg.sv
hdl/qmi_cell.sv
hdl/qmi_ctrl.sv
hdl/queue_with_middle_insert_top.sv
tb/testbench.sv
